### hw/rtl/euler_zyx_rate_kinematics_top_assert.svh
// ----------------------------------------------------------------------------
// euler zyx rate kinematics assertion macros
// checks sampled on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EULER_ZYX_RATE_KINEMATICS_TOP_ASSERT_SVH
`define EULER_ZYX_RATE_KINEMATICS_TOP_ASSERT_SVH

// a fixed number of cycles after the trigger the consequence must hold
`define EZRK_ASSERT_AFTER(lbl, trig, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig) |-> ##n (cons)) else $error(msg);

// whenever the condition holds the check must hold in the same cycle
`define EZRK_ASSERT_WHEN(lbl, cond, chk, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (chk)) else $error(msg);

`endif

### hw/rtl/ezrk_pkg.sv
// ----------------------------------------------------------------------------
// ezrk_pkg
// item types, widths and the output saturation helper
// ----------------------------------------------------------------------------
package ezrk_pkg;

    localparam int ANGLE_W = 16;
    localparam int RATE_W  = 24;
    localparam int COS_W   = 15;
    localparam int SINE_W  = 16;
    localparam int DIV_QW  = RATE_W + 2;
    localparam int MAG_W   = RATE_W + 3;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [RATE_W-1:0]  body_rate_x;
        logic signed [RATE_W-1:0]  body_rate_y;
        logic signed [RATE_W-1:0]  body_rate_z;
    } item_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] roll_rate;
        logic signed [RATE_W-1:0] pitch_rate;
        logic signed [RATE_W-1:0] yaw_rate;
        logic                     cos_floored;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic                     flag;
        logic signed [RATE_W-1:0] value;
    } sat_t;

    // clip a sign and magnitude pair to the rate range
    function automatic sat_t saturate(input logic neg, input logic [MAG_W-1:0] mag);
        sat_t res;
        res.flag  = 1'b0;
        res.value = RATE_W'(mag);
        if (neg) begin
            if (mag > (MAG_W'(1) << (RATE_W - 1))) begin
                res.flag  = 1'b1;
                res.value = {1'b1, {(RATE_W-1){1'b0}}};
            end else begin
                res.value = -$signed(RATE_W'(mag));
            end
        end else if (mag > ((MAG_W'(1) << (RATE_W - 1)) - MAG_W'(1))) begin
            res.flag  = 1'b1;
            res.value = {1'b0, {(RATE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### hw/rtl/euler_zyx_rate_kinematics_top.sv
// ----------------------------------------------------------------------------
// euler_zyx_rate_kinematics_top
// zyx euler angle rates from roll, pitch and body rates
// ----------------------------------------------------------------------------
// usage:
//   an item (roll, pitch, p, q, r) is taken at each clock edge where start
//   is high; busy is always low, so one item per cycle is accepted.
//   each result shows on result for exactly one cycle with done high,
//   in item order. the path runs through rom read, multiply, add, round
//   and multiply stages, then the two restoring dividers (one quotient
//   bit per stage).
//   the floor register floor_reg is written through cfg_valid and
//   cfg_data, cfg_ready is always high; write it only while no item is in
//   flight. a floor of zero acts as one.
//   reset clears the pipeline valid bits and sets the floor to one; items
//   in flight at reset are dropped.
//   the receiver cannot stall: a result must be taken in its done cycle.
// ----------------------------------------------------------------------------
`include "euler_zyx_rate_kinematics_top_assert.svh"

module euler_zyx_rate_kinematics_top
    import ezrk_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [COS_W-1:0] cfg_data
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int QTR_W   = ANGLE_W - 2;
    localparam int SCL_W   = QTR_W + IDX_W + 1;
    localparam int PR_W    = RATE_W + SINE_W;
    localparam int S_W     = PR_W + 1;
    localparam int SM_W    = RATE_W + 16;
    localparam int N_W     = SM_W + COS_W;
    localparam int NY_W    = DIV_QW + 16;
    localparam int NT_W    = DIV_QW + 30;
    localparam int LATENCY = DIV_QW + 7;

    localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(1) << QTR_W;

    typedef struct packed {
        logic                 neg;
        logic [IDX_W-1:0]     addr;
    } tap_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] p;
        logic [COS_W-1:0]         ctm;
        logic                     cneg;
        logic [COS_W-1:0]         sthm;
        logic                     sth_neg;
        logic                     floored;
    } mid_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] p;
        sat_t                     pd;
        logic                     floored;
        logic                     yaw_neg;
        logic                     tan_neg;
    } side_t;

    function automatic tap_t tap_of(input logic [ANGLE_W-1:0] ang);
        logic [SCL_W-1:0] scaled;
        logic [SCL_W-1:0] idx;
        tap_t             t;
        scaled = SCL_W'(ang[QTR_W-1:0]) * SCL_W'(SINE_TABLE_DEPTH)
               + SCL_W'(QUARTER >> 1);
        idx = scaled >> QTR_W;
        if (idx > SCL_W'(SINE_TABLE_DEPTH)) begin
            idx = SCL_W'(SINE_TABLE_DEPTH);
        end
        t.addr = ang[ANGLE_W-2] ? IDX_W'(SCL_W'(SINE_TABLE_DEPTH) - idx) : IDX_W'(idx);
        t.neg  = ang[ANGLE_W-1];
        return t;
    endfunction

    function automatic logic signed [SINE_W-1:0] signed_sine(
        input logic neg, input logic [COS_W-1:0] v);
        logic signed [SINE_W-1:0] w;
        w = $signed({1'b0, v});
        return neg ? -w : w;
    endfunction

    logic             accept;
    logic [COS_W-1:0] floor_reg;
    logic [COS_W-1:0] floor_mag;

    tap_t tap_sphi, tap_cphi, tap_sth, tap_cth;
    logic [COS_W-1:0] rom_sphi, rom_cphi, rom_sth, rom_cth;

    // stage a
    logic                     a_vld_reg;
    logic [3:0]               a_neg_reg;
    logic signed [RATE_W-1:0] a_p_reg, a_q_reg, a_r_reg;

    // stage b
    logic                     b_vld_reg;
    logic signed [PR_W-1:0]   b_sq_reg, b_cr_reg, b_cq_reg, b_sr_reg;
    mid_t                     b_mid_reg, b_mid_next;
    logic signed [SINE_W-1:0] sphi, cphi;

    // stage c
    logic                     c_vld_reg;
    logic signed [S_W-1:0]    c_s_reg, c_pd_reg;
    mid_t                     c_mid_reg;

    // stage d
    logic                     d_vld_reg;
    logic [SM_W-1:0]          d_smag_reg;
    logic                     d_sneg_reg;
    sat_t                     d_pd_reg;
    mid_t                     d_mid_reg;
    logic [S_W-1:0]           pd_abs;
    logic [MAG_W-1:0]         pd_round;

    // stage e
    logic                     e_vld_reg;
    logic [N_W-1:0]           e_n_reg;
    logic [NY_W-1:0]          e_ny_reg;
    logic [COS_W-1:0]         e_ctm_reg;
    side_t                    e_side_reg;

    logic [NT_W-1:0]          nt;
    logic [DIV_QW-1:0]        yaw_quo, tan_quo;

    logic                     dl_vld_reg  [0:DIV_QW];
    side_t                    dl_side_reg [0:DIV_QW];

    side_t                    f_side;
    logic signed [MAG_W:0]    tan_s, roll_sum;
    logic [MAG_W-1:0]         roll_mag;
    sat_t                     roll_sat, yaw_sat;
    result_t                  result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign floor_mag = (floor_reg == '0) ? COS_W'(1) : floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            floor_reg <= COS_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            floor_reg <= cfg_data;
        end
    end

    assign tap_sphi = tap_of(item.roll_angle);
    assign tap_cphi = tap_of(ANGLE_W'(item.roll_angle + QUARTER));
    assign tap_sth  = tap_of(item.pitch_angle);
    assign tap_cth  = tap_of(ANGLE_W'(item.pitch_angle + QUARTER));

    ezrk_rom #(.DEPTH(SINE_TABLE_DEPTH), .ADDR_W(IDX_W)) u_rom_roll (
        .clk   (clk),
        .addr0 (tap_sphi.addr),
        .addr1 (tap_cphi.addr),
        .data0 (rom_sphi),
        .data1 (rom_cphi)
    );

    ezrk_rom #(.DEPTH(SINE_TABLE_DEPTH), .ADDR_W(IDX_W)) u_rom_pitch (
        .clk   (clk),
        .addr0 (tap_sth.addr),
        .addr1 (tap_cth.addr),
        .data0 (rom_sth),
        .data1 (rom_cth)
    );

    always_ff @(posedge clk)
    begin
        a_neg_reg <= {tap_cth.neg, tap_sth.neg, tap_cphi.neg, tap_sphi.neg};
        a_p_reg   <= item.body_rate_x;
        a_q_reg   <= item.body_rate_y;
        a_r_reg   <= item.body_rate_z;
    end

    // stage b: sign the sines, four products, floor the pitch cosine
    assign sphi = signed_sine(a_neg_reg[0], rom_sphi);
    assign cphi = signed_sine(a_neg_reg[1], rom_cphi);

    always_comb
    begin
        b_mid_next.p       = a_p_reg;
        b_mid_next.sthm    = rom_sth;
        b_mid_next.sth_neg = a_neg_reg[2] && (rom_sth != '0);
        b_mid_next.cneg    = a_neg_reg[3] && (rom_cth != '0);
        b_mid_next.ctm     = rom_cth;
        b_mid_next.floored = 1'b0;
        if (rom_cth < floor_mag) begin
            b_mid_next.ctm     = floor_mag;
            b_mid_next.floored = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sq_reg  <= sphi * a_q_reg;
        b_cr_reg  <= cphi * a_r_reg;
        b_cq_reg  <= cphi * a_q_reg;
        b_sr_reg  <= sphi * a_r_reg;
        b_mid_reg <= b_mid_next;
    end

    always_ff @(posedge clk)
    begin
        c_s_reg   <= S_W'(b_sq_reg) + S_W'(b_cr_reg);
        c_pd_reg  <= S_W'(b_cq_reg) - S_W'(b_sr_reg);
        c_mid_reg <= b_mid_reg;
    end

    // stage d: magnitude of s, pitch rate rounded half away from zero
    assign pd_abs   = c_pd_reg[S_W-1] ? S_W'(-c_pd_reg) : S_W'(c_pd_reg);
    assign pd_round = MAG_W'((pd_abs + S_W'(1 << 14)) >> 15);

    always_ff @(posedge clk)
    begin
        d_smag_reg <= c_s_reg[S_W-1] ? SM_W'(-c_s_reg) : SM_W'(c_s_reg);
        d_sneg_reg <= c_s_reg[S_W-1];
        d_pd_reg   <= saturate(c_pd_reg[S_W-1], pd_round);
        d_mid_reg  <= c_mid_reg;
    end

    always_ff @(posedge clk)
    begin
        e_n_reg            <= N_W'(d_smag_reg) * N_W'(d_mid_reg.sthm);
        e_ny_reg           <= NY_W'({d_smag_reg, 1'b0}) + NY_W'(d_mid_reg.ctm);
        e_ctm_reg          <= d_mid_reg.ctm;
        e_side_reg.p       <= d_mid_reg.p;
        e_side_reg.pd      <= d_pd_reg;
        e_side_reg.floored <= d_mid_reg.floored;
        e_side_reg.yaw_neg <= d_sneg_reg ^ d_mid_reg.cneg;
        e_side_reg.tan_neg <= d_sneg_reg ^ d_mid_reg.sth_neg ^ d_mid_reg.cneg;
    end

    // tangent term: round(s*sin / (cos * 2^15)), yaw: round(s / cos)
    assign nt = NT_W'(e_n_reg) + NT_W'({e_ctm_reg, 14'b0});

    ezrk_div #(.NUM_W(NY_W), .DEN_W(16), .QUO_W(DIV_QW)) u_div_yaw (
        .clk (clk),
        .num (e_ny_reg),
        .den ({e_ctm_reg, 1'b0}),
        .quo (yaw_quo)
    );

    ezrk_div #(.NUM_W(NT_W), .DEN_W(30), .QUO_W(DIV_QW)) u_div_tan (
        .clk (clk),
        .num (nt),
        .den ({e_ctm_reg, 15'b0}),
        .quo (tan_quo)
    );

    always_ff @(posedge clk)
    begin
        dl_side_reg[0] <= e_side_reg;
        for (int i = 1; i <= DIV_QW; i++) begin
            dl_side_reg[i] <= dl_side_reg[i-1];
        end
    end

    // final stage: roll = p + tangent term, clip roll and yaw (pitch is clipped in stage d)
    assign f_side   = dl_side_reg[DIV_QW];
    assign tan_s    = f_side.tan_neg ? -$signed((MAG_W+1)'(tan_quo))
                                     : $signed((MAG_W+1)'(tan_quo));
    assign roll_sum = (MAG_W+1)'(f_side.p) + tan_s;
    assign roll_mag = roll_sum[MAG_W] ? MAG_W'(-roll_sum) : MAG_W'(roll_sum);
    assign roll_sat = saturate(roll_sum[MAG_W], roll_mag);
    assign yaw_sat  = saturate(f_side.yaw_neg, MAG_W'(yaw_quo));

    always_comb
    begin
        result_next.roll_rate   = roll_sat.value;
        result_next.pitch_rate  = f_side.pd.value;
        result_next.yaw_rate    = yaw_sat.value;
        result_next.cos_floored = f_side.floored;
        result_next.saturated   = roll_sat.flag || f_side.pd.flag || yaw_sat.flag;
    end

    always_ff @(posedge clk)
    begin
        result <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            for (int i = 0; i <= DIV_QW; i++) begin
                dl_vld_reg[i] <= 1'b0;
            end
            done <= 1'b0;
        end else begin
            a_vld_reg     <= accept;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            dl_vld_reg[0] <= e_vld_reg;
            for (int i = 1; i <= DIV_QW; i++) begin
                dl_vld_reg[i] <= dl_vld_reg[i-1];
            end
            done <= dl_vld_reg[DIV_QW];
        end
    end

    `EZRK_ASSERT_AFTER(a_item_done, accept, LATENCY, done, "accepted item gave no result")
    `EZRK_ASSERT_WHEN(a_done_item, done, $past(accept, LATENCY), "result without an item")
    `EZRK_ASSERT_AFTER(a_pd_range, dl_vld_reg[DIV_QW] && f_side.pd.flag, 1, result.saturated, "flag lost")

endmodule

### hw/rtl/ezrk_rom.sv
// ----------------------------------------------------------------------------
// ezrk_rom
// quarter-wave sine rom, two registered read ports
// ----------------------------------------------------------------------------
module ezrk_rom
    import ezrk_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] addr0,
    input  logic [ADDR_W-1:0] addr1,
    output logic [COS_W-1:0]  data0,
    output logic [COS_W-1:0]  data1
);

    localparam longint HALF_PI_Q30 = 64'd1686629713;

    logic [COS_W-1:0] rom_w [0:DEPTH];

    // taylor series of sin up to x^15 in q2.30, rounded to unsigned q0.15
    for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
        localparam longint X   = (HALF_PI_Q30 * k + DEPTH / 2) / DEPTH;
        localparam longint T1  = ((((X * X) >>> 30) * X) >>> 30) / 6;
        localparam longint T2  = ((((T1 * X) >>> 30) * X) >>> 30) / 20;
        localparam longint T3  = ((((T2 * X) >>> 30) * X) >>> 30) / 42;
        localparam longint T4  = ((((T3 * X) >>> 30) * X) >>> 30) / 72;
        localparam longint T5  = ((((T4 * X) >>> 30) * X) >>> 30) / 110;
        localparam longint T6  = ((((T5 * X) >>> 30) * X) >>> 30) / 156;
        localparam longint T7  = ((((T6 * X) >>> 30) * X) >>> 30) / 210;
        localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
        localparam longint POS = (SUM < 0) ? 0 : SUM;
        localparam longint RND = (POS + 16384) >>> 15;

        assign rom_w[k] = COS_W'((RND > 32767) ? 32767 : RND);
    end

    always_ff @(posedge clk)
    begin
        data0 <= rom_w[addr0];
        data1 <= rom_w[addr1];
    end

endmodule

### hw/rtl/ezrk_div.sv
// ----------------------------------------------------------------------------
// ezrk_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module ezrk_div
    import ezrk_pkg::*;
#(
    parameter int NUM_W = 42,
    parameter int DEN_W = 16,
    parameter int QUO_W = 26
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [0:QUO_W];
    logic [QUO_W-1:0] low_reg [0:QUO_W];
    logic [QUO_W-1:0] acc_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic             ovf_reg [0:QUO_W];

    // high part not below the divisor means the quotient does not fit
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= num[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den);
        rem_reg[0] <= num[QUO_W +: DEN_W];
        low_reg[0] <= num[QUO_W-1:0];
        acc_reg[0] <= '0;
        den_reg[0] <= den;
    end

    for (genvar i = 1; i <= QUO_W; i++) begin : g_step
        logic [DEN_W:0] trial;
        logic           take;

        assign trial = {rem_reg[i-1], low_reg[i-1][QUO_W-1]};
        assign take  = trial >= {1'b0, den_reg[i-1]};

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? DEN_W'(trial - {1'b0, den_reg[i-1]}) : trial[DEN_W-1:0];
            low_reg[i] <= low_reg[i-1] << 1;
            acc_reg[i] <= {acc_reg[i-1][QUO_W-2:0], take};
            den_reg[i] <= den_reg[i-1];
            ovf_reg[i] <= ovf_reg[i-1];
        end
    end

    assign quo = ovf_reg[QUO_W] ? {QUO_W{1'b1}} : acc_reg[QUO_W];

endmodule

### dv/euler_zyx_rate_kinematics_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_zyx_rate_kinematics_top_tb
// drives roll, pitch and body rate items into the block, predicts the euler
// rates with an independent fixed point model and compares every result
// ----------------------------------------------------------------------------
module euler_zyx_rate_kinematics_top_tb
    import ezrk_pkg::*;
();

    localparam int DEPTH    = 1024;
    localparam int LATENCY  = 33;
    localparam int QUARTER  = 1 << (ANGLE_W - 2);
    localparam int MAX_ERRS = 10;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             done;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [COS_W-1:0] cfg_data;

    longint  sine_table [DEPTH+1];
    logic [COS_W-1:0] cos_floor;
    result_t rates_q [$];
    int      mismatches;
    int      sender_idle_pct;

    euler_zyx_rate_kinematics_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic build_sine_table();
        longint x;
        longint term;
        longint sum;
        for (int k = 0; k <= DEPTH; k++)
        begin
            x = (64'd1686629713 * k + DEPTH / 2) / DEPTH;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x) >>> 30) * x >>> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum -= term;
                else
                    sum += term;
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + (1 << 14)) >>> 15;
            if (sum > 32767)
                sum = 32767;
            sine_table[k] = sum;
        end
    endtask

    function automatic longint sine_lookup(input logic [ANGLE_W-1:0] ang);
        logic [1:0] quad;
        longint     u;
        longint     idx;
        longint     v;
        quad = ang[ANGLE_W-1 -: 2];
        u = ang[ANGLE_W-3:0];
        idx = (u * DEPTH + QUARTER / 2) / QUARTER;
        if (idx > DEPTH)
            idx = DEPTH;
        v = quad[0] ? sine_table[DEPTH - idx] : sine_table[idx];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [RATE_W-1:0] clip_rate(input longint v, inout bit flag);
        longint hi;
        hi = (longint'(1) <<< (RATE_W - 1)) - 1;
        if (v > hi)
        begin
            v = hi;
            flag = 1'b1;
        end
        if (v < -hi - 1)
        begin
            v = -hi - 1;
            flag = 1'b1;
        end
        return v[RATE_W-1:0];
    endfunction

    function automatic result_t euler_rates(input item_t it, input logic [COS_W-1:0] flr);
        longint  lim;
        longint  sphi, cphi, sth, cth, p, q, r, s, d, pd, yaw, tm, t;
        longint  flm, ctm, smag, ym, dv, q1, rem;
        bit      cneg, sneg, sat;
        result_t res;
        lim  = longint'(1) <<< (RATE_W + 1);
        sphi = sine_lookup(it.roll_angle);
        cphi = sine_lookup(it.roll_angle + QUARTER);
        sth  = sine_lookup(it.pitch_angle);
        cth  = sine_lookup(it.pitch_angle + QUARTER);
        p = it.body_rate_x;
        q = it.body_rate_y;
        r = it.body_rate_z;
        sat = 1'b0;
        res.cos_floored = 1'b0;
        flm = (flr == 0) ? 1 : flr;
        cneg = cth < 0;
        ctm = abs64(cth);
        if (ctm < flm)
        begin
            ctm = flm;
            res.cos_floored = 1'b1;
        end
        s = sphi * q + cphi * r;
        d = cphi * q - sphi * r;
        pd = (abs64(d) + (1 << 14)) >>> 15;
        if (d < 0)
            pd = -pd;
        sneg = s < 0;
        smag = abs64(s);
        ym = (2 * smag + ctm) / (2 * ctm);
        if (ym > lim)
            ym = lim;
        yaw = (sneg != cneg) ? -ym : ym;
        if (sth == 0 || smag == 0)
            tm = 0;
        else
        begin
            dv = ctm <<< 15;
            q1 = smag / dv;
            rem = smag % dv;
            if (q1 > lim)
                tm = lim;
            else
                tm = q1 * abs64(sth) + (rem * abs64(sth) + dv / 2) / dv;
            if (tm > lim)
                tm = lim;
        end
        t = ((sneg != (sth < 0)) != cneg) ? -tm : tm;
        res.roll_rate  = clip_rate(p + t, sat);
        res.pitch_rate = clip_rate(pd, sat);
        res.yaw_rate   = clip_rate(yaw, sat);
        res.saturated  = sat;
        return res;
    endfunction

    // result checker, the block cannot be held off
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (rates_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_ERRS)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = rates_q.pop_front();
                if (result.roll_rate !== want.roll_rate
                    || result.pitch_rate !== want.pitch_rate
                    || result.yaw_rate !== want.yaw_rate
                    || result.cos_floored !== want.cos_floored
                    || result.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= MAX_ERRS)
                        $display("mismatch: exp roll %0d pitch %0d yaw %0d fl %b sat %b",
                                 want.roll_rate, want.pitch_rate, want.yaw_rate,
                                 want.cos_floored, want.saturated,
                                 " / got roll %0d pitch %0d yaw %0d fl %b sat %b",
                                 result.roll_rate, result.pitch_rate, result.yaw_rate,
                                 result.cos_floored, result.saturated);
                end
            end
        end
    end

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        rates_q.push_back(euler_rates(it, cos_floor));
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rates_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4)
            @(negedge clk);
    endtask

    task automatic write_floor(input logic [COS_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cos_floor = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t random_item();
        item_t it;
        it.roll_angle  = ANGLE_W'($urandom);
        it.pitch_angle = ANGLE_W'($urandom);
        it.body_rate_x = RATE_W'($urandom);
        it.body_rate_y = RATE_W'($urandom);
        it.body_rate_z = RATE_W'($urandom);
        case ($urandom_range(3))
            0: it.pitch_angle = 16'sh4000 + $signed(16'($urandom_range(64))) - 16'sd32;
            1:
            begin
                it.body_rate_x = $signed(24'($urandom_range(2047))) - 24'sd1024;
                it.body_rate_y = $signed(24'($urandom_range(65535))) - 24'sd32768;
                it.body_rate_z = $signed(24'($urandom_range(65535))) - 24'sd32768;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic test_extremes();
        item_t it;
        logic signed [ANGLE_W-1:0] angs [6];
        logic signed [RATE_W-1:0]  rts [4];
        angs = '{16'sh0000, 16'sh4000, -16'sh4000, 16'sh7fff, -16'sh8000, 16'sh2000};
        rts  = '{24'sh000000, 24'sh7fffff, -24'sh800000, 24'sh010000};
        for (int i = 0; i < 24; i++)
        begin
            it.roll_angle  = angs[i % 6];
            it.pitch_angle = angs[(i / 4) % 6];
            it.body_rate_x = rts[i % 4];
            it.body_rate_y = rts[(i + 1) % 4];
            it.body_rate_z = rts[(i / 6) % 4];
            send_item(it);
        end
    endtask

    task automatic test_gimbal_lock();
        item_t it;
        write_floor(15'h7fff);
        for (int i = 0; i < 10; i++)
        begin
            it = random_item();
            it.pitch_angle = (i % 2) ? 16'sh4000 : -16'sh4000;
            send_item(it);
        end
        write_floor(15'd0);
        for (int i = 0; i < 10; i++)
            send_item(random_item());
    endtask

    task automatic test_random(input int count, input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 128 == 127)
            begin
                write_floor(15'($urandom_range(32767, 1)));
                sender_idle_pct = idle_pct;
            end
            send_item(random_item());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        cos_floor = 15'd1;
        mismatches = 0;
        sender_idle_pct = 0;
        build_sine_table();
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_gimbal_lock();
        write_floor(15'd1);
        test_random(502, 9);
        test_random(502, 74);
        test_random(502, 0);
        drain();
        if (mismatches == 0 && rates_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
